// ===== design/mrtu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU request framer package
// Shared types, constants and the sequencer's control store.
// ----------------------------------------------------------------------------
package mrtu_pkg;

   localparam int unsigned PC_W = 5;

   localparam logic [7:0] FUNC_RW_MULTI = 8'h17;
   localparam logic [7:0] FUNC_WR_MULTI = 8'h10;
   localparam logic [7:0] RW_BYTE_COUNT = 8'h02;
   localparam logic [15:0] CRC_SEED = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0] DEV_ADDR_RESET = 8'h01;

   localparam logic REQ_RW_MULTI = 1'b0;
   localparam logic REQ_WR_MULTI = 1'b1;

   localparam logic [PC_W-1:0] PC_START = 5'd0;
   localparam logic [PC_W-1:0] PC_WR_ENTRY = 5'd16;

   typedef enum logic [3:0] {
      SRC_DEV_ADDR,
      SRC_CONST,
      SRC_RADDR_HI,
      SRC_RADDR_LO,
      SRC_RCNT_HI,
      SRC_RCNT_LO,
      SRC_WADDR_HI,
      SRC_WADDR_LO,
      SRC_WCNT_HI,
      SRC_WCNT_LO,
      SRC_BYTE_CNT,
      SRC_VALUE_HI,
      SRC_VALUE_LO,
      SRC_CRC_LO,
      SRC_CRC_HI
   } src_type;

   typedef struct packed {
      src_type         src;
      logic [7:0]      konst;
      logic            crc_upd;
      logic            last;
      logic            jmp_wr;
      logic [PC_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic       step;
      logic       init;
      logic       upd;
      logic [7:0] data;
   } crc_ctl_type;

   function automatic ucode_type uword(input src_type src, input logic [7:0] konst,
                                       input logic crc_upd, input logic last);
      ucode_type w;
      w.src     = src;
      w.konst   = konst;
      w.crc_upd = crc_upd;
      w.last    = last;
      w.jmp_wr  = 1'b0;
      w.target  = PC_START;
      return w;
   endfunction

   // Step 0 is shared and branches on the request kind; read/write multiple
   // runs from step 1, write multiple from step 16.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      unique case (pc)
         5'd0: begin
            w = uword(SRC_DEV_ADDR, 8'h00, 1'b1, 1'b0);
            w.jmp_wr = 1'b1;
            w.target = PC_WR_ENTRY;
         end
         5'd1:  w = uword(SRC_CONST, FUNC_RW_MULTI, 1'b1, 1'b0);
         5'd2:  w = uword(SRC_RADDR_HI, 8'h00, 1'b1, 1'b0);
         5'd3:  w = uword(SRC_RADDR_LO, 8'h00, 1'b1, 1'b0);
         5'd4:  w = uword(SRC_RCNT_HI, 8'h00, 1'b1, 1'b0);
         5'd5:  w = uword(SRC_RCNT_LO, 8'h00, 1'b1, 1'b0);
         5'd6:  w = uword(SRC_WADDR_HI, 8'h00, 1'b1, 1'b0);
         5'd7:  w = uword(SRC_WADDR_LO, 8'h00, 1'b1, 1'b0);
         5'd8:  w = uword(SRC_WCNT_HI, 8'h00, 1'b1, 1'b0);
         5'd9:  w = uword(SRC_WCNT_LO, 8'h00, 1'b1, 1'b0);
         5'd10: w = uword(SRC_CONST, RW_BYTE_COUNT, 1'b1, 1'b0);
         5'd11: w = uword(SRC_VALUE_HI, 8'h00, 1'b1, 1'b0);
         5'd12: w = uword(SRC_VALUE_LO, 8'h00, 1'b1, 1'b0);
         5'd13: w = uword(SRC_CRC_LO, 8'h00, 1'b0, 1'b0);
         5'd14: w = uword(SRC_CRC_HI, 8'h00, 1'b0, 1'b1);
         5'd16: w = uword(SRC_CONST, FUNC_WR_MULTI, 1'b1, 1'b0);
         5'd17: w = uword(SRC_WADDR_HI, 8'h00, 1'b1, 1'b0);
         5'd18: w = uword(SRC_WADDR_LO, 8'h00, 1'b1, 1'b0);
         5'd19: w = uword(SRC_WCNT_HI, 8'h00, 1'b1, 1'b0);
         5'd20: w = uword(SRC_WCNT_LO, 8'h00, 1'b1, 1'b0);
         5'd21: w = uword(SRC_BYTE_CNT, 8'h00, 1'b1, 1'b0);
         5'd22: w = uword(SRC_VALUE_HI, 8'h00, 1'b1, 1'b0);
         5'd23: w = uword(SRC_VALUE_LO, 8'h00, 1'b1, 1'b0);
         5'd24: w = uword(SRC_CRC_LO, 8'h00, 1'b0, 1'b0);
         5'd25: w = uword(SRC_CRC_HI, 8'h00, 1'b0, 1'b1);
         default: w = uword(SRC_CONST, 8'h00, 1'b0, 1'b1);
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// ===== design/mrtu_crc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU CRC-16 accumulator
// Folds one frame byte per step into the running CRC (reflected 0xA001).
// ----------------------------------------------------------------------------
module mrtu_crc
   import mrtu_pkg::*;
(
   input  wire logic        clock,
   input  wire crc_ctl_type ctl,
   output logic [15:0]      crc
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   always_comb begin
      logic [15:0] c;
      c = (ctl.init ? CRC_SEED : crc_ff) ^ {8'h00, ctl.data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      crc_in = c;
   end

   always_ff @(posedge clock) begin
      if (ctl.step && ctl.upd) begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_ff;

endmodule
`default_nettype wire

// ===== design/modbus_rtu_request_framer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU request framer
// Turns each request into its Modbus RTU frame, one byte per response beat,
// with the CRC-16 appended low byte first and tlast on the final byte.
// ----------------------------------------------------------------------------
//   Channel  Direction  Payload
//   req_*    in         tdata: fields, tuser: request kind
//   rsp_*    out        tdata: frame byte, tlast: final CRC byte
//   csr_*    in         device address
//
// A microcoded sequencer loads one frame byte per cycle into the output
// register, the first at the edge that accepts the request: 15 bytes for
// read/write multiple and 11 for write multiple. A new request can be taken at
// the edge at which the last byte of the previous frame leaves the output
// register. Back-pressure on rsp stalls the step counter. Reset is synchronous
// and needs no clearing pass.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer_unit
   import mrtu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [15:0] rd_start, [31:16] read_count, [47:32] wr_start,
   // [63:48] write_count, [79:64] value
   input  wire logic [79:0] req_tdata,
   // [0] req_type
   input  wire logic [0:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] frame_byte
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_wdata
);

   logic [PC_W-1:0] pc_ff, pc_in;
   logic            busy_ff, busy_in;
   logic            kind_ff;
   logic [7:0]      dev_addr_ff;
   logic [15:0]     raddr_ff, rcnt_ff, waddr_ff, wcnt_ff, value_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_data_ff;
   logic            rsp_last_ff;

   ucode_type   uw;
   crc_ctl_type crc_ctl;
   logic [15:0] crc;
   logic        out_free;
   logic        step;
   logic        accept;
   logic        kind;
   logic [7:0]  byte_sel;

   assign uw       = ucode_rom(pc_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign step     = out_free && (busy_ff || req_tvalid);
   assign accept   = req_tvalid && !busy_ff && out_free;
   assign kind     = busy_ff ? kind_ff : req_tuser[0];

   assign req_tready = !busy_ff && out_free;
   assign csr_ready  = 1'b1;

   always_comb begin
      unique case (uw.src)
         SRC_DEV_ADDR: byte_sel = dev_addr_ff;
         SRC_CONST:    byte_sel = uw.konst;
         SRC_RADDR_HI: byte_sel = raddr_ff[15:8];
         SRC_RADDR_LO: byte_sel = raddr_ff[7:0];
         SRC_RCNT_HI:  byte_sel = rcnt_ff[15:8];
         SRC_RCNT_LO:  byte_sel = rcnt_ff[7:0];
         SRC_WADDR_HI: byte_sel = waddr_ff[15:8];
         SRC_WADDR_LO: byte_sel = waddr_ff[7:0];
         SRC_WCNT_HI:  byte_sel = wcnt_ff[15:8];
         SRC_WCNT_LO:  byte_sel = wcnt_ff[7:0];
         SRC_BYTE_CNT: byte_sel = {wcnt_ff[6:0], 1'b0};
         SRC_VALUE_HI: byte_sel = value_ff[15:8];
         SRC_VALUE_LO: byte_sel = value_ff[7:0];
         SRC_CRC_LO:   byte_sel = crc[7:0];
         SRC_CRC_HI:   byte_sel = crc[15:8];
         default:      byte_sel = uw.konst;
      endcase
   end

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (step) begin
         busy_in = !uw.last;
         priority if (uw.last) begin
            pc_in = PC_START;
         end else if (uw.jmp_wr && kind == REQ_WR_MULTI) begin
            pc_in = uw.target;
         end else begin
            pc_in = pc_ff + 5'd1;
         end
      end
      rsp_valid_in = step ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   assign crc_ctl.step = step;
   assign crc_ctl.init = (pc_ff == PC_START);
   assign crc_ctl.upd  = uw.crc_upd;
   assign crc_ctl.data = byte_sel;

   mrtu_crc u_crc (
      .clock (clock),
      .ctl   (crc_ctl),
      .crc   (crc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_START;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dev_addr_ff  <= DEV_ADDR_RESET;
      end else begin
         pc_ff        <= pc_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            dev_addr_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_tuser[0];
         raddr_ff <= req_tdata[15:0];
         rcnt_ff  <= req_tdata[31:16];
         waddr_ff <= req_tdata[47:32];
         wcnt_ff  <= req_tdata[63:48];
         value_ff <= (req_tuser[0] == REQ_RW_MULTI) ? 16'(16'd0 - req_tdata[79:64])
                                                    : req_tdata[79:64];
      end
      if (step) begin
         rsp_data_ff <= byte_sel;
         rsp_last_ff <= uw.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

// ===== design/mrtu_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU request framer checker
// Port-level checks on request and response sequencing.
// ----------------------------------------------------------------------------
module mrtu_checker
   import mrtu_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("Stalled response changed.");

   a_first_byte: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid && !rsp_tlast)
      else $error("Accepted request did not present its first byte.");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Request accepted while a frame is in progress.");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("Response valid after reset.");

endmodule

bind modbus_rtu_request_framer_unit mrtu_checker u_mrtu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
